// File: rtl/core/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Shared widths, register codes, types and fixed-point helpers for the ray
// axis pick block.
// ----------------------------------------------------------------------------
package rap_pkg;

   localparam int W         = 32;
   localparam int FRAC_BITS = 16;
   localparam int NUM_AXES  = 3;
   localparam int CFG_W     = 31;
   localparam int AXIS_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam int PROD_W   = 2 * W - FRAC_BITS;
   localparam int SUM_W    = PROD_W + 2;
   localparam int DIV_W    = W + FRAC_BITS;
   localparam int SQ_W     = 2 * W;
   localparam int REM_W    = W + 3;
   localparam int LANE_PRE = 3;
   localparam int WV_DLY   = LANE_PRE + DIV_W + 1;

   localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARALLEL_EPS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PICK_THRESHOLD = 2'd2;

   localparam logic [CFG_W-1:0] AXIS_LENGTH_RST    = CFG_W'(65536);
   localparam logic [CFG_W-1:0] PARALLEL_EPS_RST   = CFG_W'(66);
   localparam logic [CFG_W-1:0] PICK_THRESHOLD_RST = CFG_W'(6554);

   typedef logic signed [W-1:0]      fix_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef fix_type [NUM_AXES-1:0]   vec3_type;

   typedef struct packed {
      fix_type a;
      fix_type b;
      fix_type c;
      fix_type d;
      fix_type e;
   } coef_type;

   typedef struct packed {
      logic [W-1:0]     rem;
      logic [DIV_W-1:0] acc;
      logic [W-1:0]     m;
      logic             neg;
      logic             zero;
   } div_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [SQ_W-1:0]  acc;
      logic [W-1:0]     root;
   } sqrt_type;

   // Product floored by the fraction bits.
   function automatic prod_type fmul(input fix_type x, input fix_type y);
      logic signed [2*W-1:0] p;
      p = (2*W)'(x) * (2*W)'(y);
      return PROD_W'(p >>> FRAC_BITS);
   endfunction

   function automatic fix_type sat32(input sum_type v);
      if ((v[SUM_W-1:W-1] == '0) || (v[SUM_W-1:W-1] == '1)) begin
         return v[W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(W-1){1'b0}}};
      end else begin
         return {1'b0, {(W-1){1'b1}}};
      end
   endfunction

   function automatic fix_type neg_sat(input fix_type x);
      sum_type t;
      t = SUM_W'(x);
      return sat32(-t);
   endfunction

endpackage

// File: rtl/core/rap_lane.sv
// ----------------------------------------------------------------------------
// rap_lane
// Distance pipeline for one axis: solve, two pipelined dividers, closest
// point difference and a pipelined integer square root.
// ----------------------------------------------------------------------------
module rap_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic [rap_pkg::AXIS_W-1:0]   axis,
   input  logic [rap_pkg::CFG_W-1:0]    axis_length,
   input  logic [rap_pkg::CFG_W-1:0]    parallel_eps,
   input  logic                         in_valid,
   input  rap_pkg::coef_type            coef,
   input  rap_pkg::vec3_type            w_late,
   input  rap_pkg::vec3_type            v_late,
   output logic                         out_valid,
   output logic [rap_pkg::W-1:0]        distance
);

   rap_pkg::prod_type ac_ff, bb_ff, be_ff, cd_ff, ae_ff, bd_ff;
   rap_pkg::fix_type  b4_ff, c4_ff, d4_ff, e4_ff;
   logic              val4_ff;

   rap_pkg::fix_type  den_ff, nsc_ff, ntc_ff;
   rap_pkg::fix_type  b5_ff, c5_ff, d5_ff, e5_ff;
   logic              val5_ff;

   rap_pkg::div_type  seed_ff [2];
   rap_pkg::div_type  seed_in [2];
   logic              val6_ff;

   rap_pkg::div_type  div_ff [2][rap_pkg::DIV_W];
   rap_pkg::div_type  div_in [2][rap_pkg::DIV_W];
   logic [rap_pkg::DIV_W-1:0] dval_ff;

   rap_pkg::fix_type  quo_in [2];
   rap_pkg::fix_type  sc_ff, tc_ff;
   logic              valq_ff;

   rap_pkg::prod_type scl_ff;
   rap_pkg::prod_type tcv_ff [rap_pkg::NUM_AXES];
   rap_pkg::vec3_type wm_ff;
   logic              valm_ff;

   logic [rap_pkg::W-1:0] mag_ff [rap_pkg::NUM_AXES];
   logic [rap_pkg::W-1:0] mag_in [rap_pkg::NUM_AXES];
   logic                  vald_ff;

   logic [rap_pkg::SQ_W-1:0] sq_ff [rap_pkg::NUM_AXES];
   logic                     valsq_ff;

   logic [rap_pkg::SQ_W-1:0] sum_ff;
   logic                     valsum_ff;

   rap_pkg::sqrt_type rt_ff [rap_pkg::W];
   rap_pkg::sqrt_type rt_in [rap_pkg::W];
   logic [rap_pkg::W-1:0] rval_ff;

   rap_pkg::fix_type len_fix;
   assign len_fix = rap_pkg::fix_type'({1'b0, axis_length});

   // Parallel test and divider operand preparation.
   always_comb begin
      logic              par;
      rap_pkg::fix_type  n [2];
      rap_pkg::fix_type  m [2];
      logic [rap_pkg::W-1:0] nm;
      logic [rap_pkg::W-1:0] mm;
      par = den_ff < rap_pkg::fix_type'({1'b0, parallel_eps});
      n[0] = par ? '0 : nsc_ff;
      m[0] = den_ff;
      if (!par) begin
         n[1] = ntc_ff;
         m[1] = den_ff;
      end else if (b5_ff > c5_ff) begin
         n[1] = d5_ff;
         m[1] = b5_ff;
      end else begin
         n[1] = e5_ff;
         m[1] = c5_ff;
      end
      for (int s = 0; s < 2; s++) begin
         nm = n[s][rap_pkg::W-1] ? rap_pkg::W'(-n[s]) : rap_pkg::W'(n[s]);
         mm = m[s][rap_pkg::W-1] ? rap_pkg::W'(-m[s]) : rap_pkg::W'(m[s]);
         seed_in[s].rem  = '0;
         seed_in[s].acc  = {nm, {rap_pkg::FRAC_BITS{1'b0}}};
         seed_in[s].m    = mm;
         seed_in[s].neg  = n[s][rap_pkg::W-1] ^ m[s][rap_pkg::W-1];
         seed_in[s].zero = (n[s] == '0);
      end
   end

   // One quotient bit per divider stage.
   always_comb begin
      rap_pkg::div_type  src;
      logic [rap_pkg::W:0] t;
      logic              ge;
      for (int s = 0; s < 2; s++) begin
         for (int j = 0; j < rap_pkg::DIV_W; j++) begin
            src = (j == 0) ? seed_ff[s] : div_ff[s][(j == 0) ? 0 : j - 1];
            t   = {src.rem, src.acc[rap_pkg::DIV_W-1]};
            ge  = t >= {1'b0, src.m};
            div_in[s][j]     = src;
            div_in[s][j].rem = ge ? rap_pkg::W'(t - {1'b0, src.m}) : t[rap_pkg::W-1:0];
            div_in[s][j].acc = {src.acc[rap_pkg::DIV_W-2:0], ge};
         end
      end
   end

   // Signed quotient with saturation.
   always_comb begin
      rap_pkg::div_type fin;
      for (int s = 0; s < 2; s++) begin
         fin = div_ff[s][rap_pkg::DIV_W-1];
         if (fin.zero) begin
            quo_in[s] = '0;
         end else if (fin.neg) begin
            if (fin.acc > (rap_pkg::DIV_W'(1) << (rap_pkg::W - 1))) begin
               quo_in[s] = {1'b1, {(rap_pkg::W-1){1'b0}}};
            end else begin
               quo_in[s] = -rap_pkg::fix_type'(fin.acc[rap_pkg::W-1:0]);
            end
         end else if (fin.acc > rap_pkg::DIV_W'({1'b0, {(rap_pkg::W-1){1'b1}}})) begin
            quo_in[s] = {1'b0, {(rap_pkg::W-1){1'b1}}};
         end else begin
            quo_in[s] = fin.acc[rap_pkg::W-1:0];
         end
      end
   end

   // Closest point difference and its magnitude per component.
   always_comb begin
      rap_pkg::sum_type t;
      rap_pkg::fix_type dp;
      for (int i = 0; i < rap_pkg::NUM_AXES; i++) begin
         t = rap_pkg::SUM_W'(wm_ff[i]) - rap_pkg::SUM_W'(tcv_ff[i]);
         if (i == int'(axis)) begin
            t = t + rap_pkg::SUM_W'(scl_ff);
         end
         dp = rap_pkg::sat32(t);
         mag_in[i] = dp[rap_pkg::W-1] ? rap_pkg::W'(-dp) : rap_pkg::W'(dp);
      end
   end

   // One root bit per square root stage.
   always_comb begin
      rap_pkg::sqrt_type src;
      logic [rap_pkg::REM_W-1:0] t;
      logic [rap_pkg::REM_W-1:0] trial;
      for (int j = 0; j < rap_pkg::W; j++) begin
         if (j == 0) begin
            src.rem  = '0;
            src.acc  = sum_ff;
            src.root = '0;
         end else begin
            src = rt_ff[(j == 0) ? 0 : j - 1];
         end
         t     = {src.rem[rap_pkg::REM_W-3:0], src.acc[rap_pkg::SQ_W-1 -: 2]};
         trial = rap_pkg::REM_W'({src.root, 2'b01});
         rt_in[j].acc = {src.acc[rap_pkg::SQ_W-3:0], 2'b00};
         if (t >= trial) begin
            rt_in[j].rem  = t - trial;
            rt_in[j].root = {src.root[rap_pkg::W-2:0], 1'b1};
         end else begin
            rt_in[j].rem  = t;
            rt_in[j].root = {src.root[rap_pkg::W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val4_ff   <= 1'b0;
         val5_ff   <= 1'b0;
         val6_ff   <= 1'b0;
         dval_ff   <= '0;
         valq_ff   <= 1'b0;
         valm_ff   <= 1'b0;
         vald_ff   <= 1'b0;
         valsq_ff  <= 1'b0;
         valsum_ff <= 1'b0;
         rval_ff   <= '0;
      end else if (en) begin
         val4_ff   <= in_valid;
         val5_ff   <= val4_ff;
         val6_ff   <= val5_ff;
         dval_ff   <= {dval_ff[rap_pkg::DIV_W-2:0], val6_ff};
         valq_ff   <= dval_ff[rap_pkg::DIV_W-1];
         valm_ff   <= valq_ff;
         vald_ff   <= valm_ff;
         valsq_ff  <= vald_ff;
         valsum_ff <= valsq_ff;
         rval_ff   <= {rval_ff[rap_pkg::W-2:0], valsum_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff <= rap_pkg::fmul(coef.a, coef.c);
         bb_ff <= rap_pkg::fmul(coef.b, coef.b);
         be_ff <= rap_pkg::fmul(coef.b, coef.e);
         cd_ff <= rap_pkg::fmul(coef.c, coef.d);
         ae_ff <= rap_pkg::fmul(coef.a, coef.e);
         bd_ff <= rap_pkg::fmul(coef.b, coef.d);
         b4_ff <= coef.b;
         c4_ff <= coef.c;
         d4_ff <= coef.d;
         e4_ff <= coef.e;

         den_ff <= rap_pkg::sat32(rap_pkg::SUM_W'(ac_ff) - rap_pkg::SUM_W'(bb_ff));
         nsc_ff <= rap_pkg::sat32(rap_pkg::SUM_W'(be_ff) - rap_pkg::SUM_W'(cd_ff));
         ntc_ff <= rap_pkg::sat32(rap_pkg::SUM_W'(ae_ff) - rap_pkg::SUM_W'(bd_ff));
         b5_ff  <= b4_ff;
         c5_ff  <= c4_ff;
         d5_ff  <= d4_ff;
         e5_ff  <= e4_ff;

         for (int s = 0; s < 2; s++) begin
            seed_ff[s] <= seed_in[s];
            for (int j = 0; j < rap_pkg::DIV_W; j++) begin
               div_ff[s][j] <= div_in[s][j];
            end
         end

         sc_ff <= quo_in[0];
         tc_ff <= quo_in[1];

         scl_ff <= rap_pkg::fmul(sc_ff, len_fix);
         for (int i = 0; i < rap_pkg::NUM_AXES; i++) begin
            tcv_ff[i] <= rap_pkg::fmul(tc_ff, v_late[i]);
            mag_ff[i] <= mag_in[i];
            sq_ff[i]  <= rap_pkg::SQ_W'(mag_ff[i]) * rap_pkg::SQ_W'(mag_ff[i]);
         end
         wm_ff <= w_late;

         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];

         for (int j = 0; j < rap_pkg::W; j++) begin
            rt_ff[j] <= rt_in[j];
         end
      end
   end

   assign out_valid = rval_ff[rap_pkg::W-1];
   assign distance  = rt_ff[rap_pkg::W-1].root;

endmodule

// File: rtl/core/ray_axis_pick_top.sv
// ----------------------------------------------------------------------------
// ray_axis_pick_top
// Picks the coordinate axis nearest to a pick ray and reports its distance.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  req      req_valid/req_ready   ray origin and direction, signed Q16.16
//  rsp      rsp_valid/rsp_ready   hit, picked axis, nearest distance
//  csr      csr_valid/csr_ready   register index and write data
//
// One word is taken every cycle while rsp is not stalled; its result passes
// through the two 48-stage dividers and the 32-stage square root.
// Reset clears all valid bits, the registers to their defaults and the
// selected axis to none. A stall on rsp freezes the whole pipeline.
// ----------------------------------------------------------------------------
module ray_axis_pick_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [rap_pkg::W-1:0]    req_ray_origin_x,
   input  logic signed [rap_pkg::W-1:0]    req_ray_origin_y,
   input  logic signed [rap_pkg::W-1:0]    req_ray_origin_z,
   input  logic signed [rap_pkg::W-1:0]    req_ray_dir_x,
   input  logic signed [rap_pkg::W-1:0]    req_ray_dir_y,
   input  logic signed [rap_pkg::W-1:0]    req_ray_dir_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [rap_pkg::AXIS_W-1:0]      rsp_picked_axis,
   output logic [rap_pkg::W-1:0]           rsp_nearest_distance,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rap_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rap_pkg::CFG_W-1:0]       csr_wdata
);

   logic en;

   logic [rap_pkg::CFG_W-1:0] axis_length_ff, parallel_eps_ff, pick_threshold_ff;

   rap_pkg::vec3_type w1_ff, v1_ff;
   logic              val1_ff;

   rap_pkg::prod_type ll_ff;
   rap_pkg::prod_type lv_ff [rap_pkg::NUM_AXES];
   rap_pkg::prod_type lw_ff [rap_pkg::NUM_AXES];
   rap_pkg::prod_type vv_ff [rap_pkg::NUM_AXES];
   rap_pkg::prod_type vw_ff [rap_pkg::NUM_AXES];
   rap_pkg::vec3_type w2_ff, v2_ff;
   logic              val2_ff;

   rap_pkg::fix_type  a_ff, c_ff, e_ff;
   rap_pkg::fix_type  b_ff [rap_pkg::NUM_AXES];
   rap_pkg::fix_type  d_ff [rap_pkg::NUM_AXES];
   rap_pkg::vec3_type w3_ff, v3_ff;
   logic              val3_ff;

   rap_pkg::vec3_type wd_ff [rap_pkg::WV_DLY];
   rap_pkg::vec3_type vd_ff [rap_pkg::WV_DLY];

   logic                  lane_valid [rap_pkg::NUM_AXES];
   logic [rap_pkg::W-1:0] lane_dist  [rap_pkg::NUM_AXES];

   logic [rap_pkg::W-1:0]      pk_dist_ff;
   logic [rap_pkg::AXIS_W-1:0] pk_axis_ff;
   logic                       pk_valid_ff;
   logic [rap_pkg::W-1:0]      best_in;
   logic [rap_pkg::AXIS_W-1:0] axis_in;

   logic                       rsp_valid_ff, rsp_hit_ff;
   logic [rap_pkg::AXIS_W-1:0] selected_axis_ff;
   logic [rap_pkg::W-1:0]      rsp_dist_ff;
   logic                       hit_in;

   rap_pkg::fix_type len_fix;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign len_fix   = rap_pkg::fix_type'({1'b0, axis_length_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_length_ff    <= rap_pkg::AXIS_LENGTH_RST;
         parallel_eps_ff   <= rap_pkg::PARALLEL_EPS_RST;
         pick_threshold_ff <= rap_pkg::PICK_THRESHOLD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            rap_pkg::CSR_AXIS_LENGTH:    axis_length_ff    <= csr_wdata;
            rap_pkg::CSR_PARALLEL_EPS:   parallel_eps_ff   <= csr_wdata;
            rap_pkg::CSR_PICK_THRESHOLD: pick_threshold_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val1_ff      <= 1'b0;
         val2_ff      <= 1'b0;
         val3_ff      <= 1'b0;
         pk_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
         selected_axis_ff <= rap_pkg::AXIS_NONE;
      end else if (en) begin
         val1_ff      <= req_valid;
         val2_ff      <= val1_ff;
         val3_ff      <= val2_ff;
         pk_valid_ff  <= lane_valid[0];
         rsp_valid_ff <= pk_valid_ff;
         if (pk_valid_ff) begin
            rsp_hit_ff       <= hit_in;
            selected_axis_ff <= hit_in ? pk_axis_ff : rap_pkg::AXIS_NONE;
         end
      end
   end

   always_comb begin
      best_in = lane_dist[0];
      axis_in = '0;
      for (int k = 1; k < rap_pkg::NUM_AXES; k++) begin
         if (lane_dist[k] < best_in) begin
            best_in = lane_dist[k];
            axis_in = rap_pkg::AXIS_W'(k);
         end
      end
   end

   assign hit_in = pk_dist_ff <= rap_pkg::W'(pick_threshold_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff[0] <= rap_pkg::neg_sat(req_ray_origin_x);
         w1_ff[1] <= rap_pkg::neg_sat(req_ray_origin_y);
         w1_ff[2] <= rap_pkg::neg_sat(req_ray_origin_z);
         v1_ff[0] <= req_ray_dir_x;
         v1_ff[1] <= req_ray_dir_y;
         v1_ff[2] <= req_ray_dir_z;

         ll_ff <= rap_pkg::fmul(len_fix, len_fix);
         for (int i = 0; i < rap_pkg::NUM_AXES; i++) begin
            lv_ff[i] <= rap_pkg::fmul(len_fix, v1_ff[i]);
            lw_ff[i] <= rap_pkg::fmul(len_fix, w1_ff[i]);
            vv_ff[i] <= rap_pkg::fmul(v1_ff[i], v1_ff[i]);
            vw_ff[i] <= rap_pkg::fmul(v1_ff[i], w1_ff[i]);
            b_ff[i]  <= rap_pkg::sat32(rap_pkg::SUM_W'(lv_ff[i]));
            d_ff[i]  <= rap_pkg::sat32(rap_pkg::SUM_W'(lw_ff[i]));
         end
         w2_ff <= w1_ff;
         v2_ff <= v1_ff;

         a_ff <= rap_pkg::sat32(rap_pkg::SUM_W'(ll_ff));
         c_ff <= rap_pkg::sat32(rap_pkg::SUM_W'(vv_ff[0]) + rap_pkg::SUM_W'(vv_ff[1])
                                + rap_pkg::SUM_W'(vv_ff[2]));
         e_ff <= rap_pkg::sat32(rap_pkg::SUM_W'(vw_ff[0]) + rap_pkg::SUM_W'(vw_ff[1])
                                + rap_pkg::SUM_W'(vw_ff[2]));
         w3_ff <= w2_ff;
         v3_ff <= v2_ff;

         wd_ff[0] <= w3_ff;
         vd_ff[0] <= v3_ff;
         for (int j = 1; j < rap_pkg::WV_DLY; j++) begin
            wd_ff[j] <= wd_ff[j-1];
            vd_ff[j] <= vd_ff[j-1];
         end

         pk_dist_ff  <= best_in;
         pk_axis_ff  <= axis_in;
         rsp_dist_ff <= pk_dist_ff;
      end
   end

   for (genvar k = 0; k < rap_pkg::NUM_AXES; k++) begin : g_lane
      rap_pkg::coef_type coef;
      assign coef.a = a_ff;
      assign coef.b = b_ff[k];
      assign coef.c = c_ff;
      assign coef.d = d_ff[k];
      assign coef.e = e_ff;

      rap_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .en           (en),
         .axis         (rap_pkg::AXIS_W'(k)),
         .axis_length  (axis_length_ff),
         .parallel_eps (parallel_eps_ff),
         .in_valid     (val3_ff),
         .coef         (coef),
         .w_late       (wd_ff[rap_pkg::WV_DLY-1]),
         .v_late       (vd_ff[rap_pkg::WV_DLY-1]),
         .out_valid    (lane_valid[k]),
         .distance     (lane_dist[k])
      );
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_picked_axis      = selected_axis_ff;
   assign rsp_nearest_distance = rsp_dist_ff;

endmodule
